>>> sv/bsab_pkg.sv
// Shared types and constants for the bilinear scale and alpha blend block.
`default_nettype none
package bsab_pkg;

	// one color component
	typedef logic [7:0] chan_t;

	// configuration register indexes (byte address is 4 * index)
	localparam logic [2:0] RegBlendRatio  = 3'd0;
	localparam logic [2:0] RegBigWidth    = 3'd1;
	localparam logic [2:0] RegBigHeight   = 3'd2;
	localparam logic [2:0] RegSmallWidth  = 3'd3;
	localparam logic [2:0] RegSmallHeight = 3'd4;

	localparam int CfgW  = 9;   // width of every configuration register
	localparam int PaddrW = 5;  // byte address of the last register fits
	// dividend pos * small * 256: 8 + 9 + 8 bits
	localparam int QuotW = 25;

	// reset values
	localparam logic [CfgW-1:0] RatioReset = 9'd128;
	localparam logic [CfgW-1:0] SizeReset  = 9'd256;

	// function codes
	localparam logic FuncLoad  = 1'b0;
	localparam logic FuncBlend = 1'b1;

endpackage
`default_nettype wire

>>> sv/bsab_if.sv
// Valid/ready channel interfaces for input items and result beats.
`default_nettype none
interface bsab_in_if import bsab_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  func;
	chan_t pos_x;
	chan_t pos_y;
	chan_t in_blue;
	chan_t in_green;
	chan_t in_red;

	modport source (output valid, func, pos_x, pos_y, in_blue, in_green, in_red,
		input ready);
	modport sink (input valid, func, pos_x, pos_y, in_blue, in_green, in_red,
		output ready);
endinterface

interface bsab_out_if import bsab_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t out_blue;
	chan_t out_green;
	chan_t out_red;

	modport source (output valid, out_blue, out_green, out_red, input ready);
	modport sink (input valid, out_blue, out_green, out_red, output ready);
endinterface
`default_nettype wire

>>> sv/bsab_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bsab_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/bilinear_scale_alpha_blend.sv
// Top level: small image store, coordinate divider, bilinear interpolator and blender.
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | func, pos_x, pos_y, in_blue, in_green, in_red
//  out_ch   | out | valid / ready    | out_blue, out_green, out_red
//  apb      | in  | psel, penable    | paddr[4:0], pwdata, prdata, pready tied high
//
// A load beat occupies the image memory for a single write, a blend beat for four
// neighbor reads on the single read port, so a new blend enters the access stage
// only once the beat ahead of it is done with the memory. From input to result
// a beat passes 26 divider registers, the access stage, four reads, the read return,
// two interpolation stages and the output register. Reset clears control state only;
// the image store holds no reset. A stalled result stalls the whole pipeline.
`default_nettype none
module bilinear_scale_alpha_blend import bsab_pkg::*; #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	bsab_in_if.sink                in_ch,
	bsab_out_if.source             out_ch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [PaddrW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AddrW = $clog2(Depth);

	typedef struct packed {
		logic              func;
		logic [7:0]        px;
		logic [7:0]        py;
		logic [23:0]       pix;
		logic [CfgW-1:0]   rx;
		logic [QuotW-1:0]  qx;
		logic [CfgW-1:0]   ry;
		logic [QuotW-1:0]  qy;
	} dstage_t;

	// ---------------- configuration registers ----------------
	logic [CfgW-1:0] ratio_q, big_w_q, big_h_q, small_w_q, small_h_q;
	logic [2:0]      reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q   <= RatioReset;
			big_w_q   <= SizeReset;
			big_h_q   <= SizeReset;
			small_w_q <= SizeReset;
			small_h_q <= SizeReset;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				RegBlendRatio:  ratio_q   <= pwdata[CfgW-1:0];
				RegBigWidth:    big_w_q   <= pwdata[CfgW-1:0];
				RegBigHeight:   big_h_q   <= pwdata[CfgW-1:0];
				RegSmallWidth:  small_w_q <= pwdata[CfgW-1:0];
				RegSmallHeight: small_h_q <= pwdata[CfgW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			RegBlendRatio:  prdata = {23'd0, ratio_q};
			RegBigWidth:    prdata = {23'd0, big_w_q};
			RegBigHeight:   prdata = {23'd0, big_h_q};
			RegSmallWidth:  prdata = {23'd0, small_w_q};
			RegSmallHeight: prdata = {23'd0, small_h_q};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- effective sizes ----------------
	function automatic logic [CfgW-1:0] nz(input logic [CfgW-1:0] v);
		return (v == '0) ? 9'd1 : v;
	endfunction

	function automatic logic [CfgW-1:0] cap(input logic [CfgW-1:0] v, input int hi);
		return (32'(v) > hi) ? CfgW'(hi) : v;
	endfunction

	logic [CfgW-1:0] bw, bh, sw, sh, ratio, sw_m1, sh_m1;

	assign bw    = nz(big_w_q);
	assign bh    = nz(big_h_q);
	assign sw    = cap(nz(small_w_q), MAX_WIDTH);
	assign sh    = cap(nz(small_h_q), MAX_HEIGHT);
	assign ratio = cap(ratio_q, 256);
	assign sw_m1 = sw - 9'd1;
	assign sh_m1 = sh - 9'd1;

	// ---------------- pipeline control ----------------
	logic       adv, div_en, a_done, a_take;
	logic       out_v_q;
	logic       a_v_s1, a_func_s1, a_wen_s1;
	logic [1:0] cnt_q;

	assign adv    = !out_v_q || out_ch.ready;
	assign a_done = a_v_s1 && (a_func_s1 == FuncLoad || cnt_q == 2'd3);
	assign a_take = adv && (!a_v_s1 || a_done);
	assign div_en = a_take;
	assign in_ch.ready = div_en;

	// ---------------- restoring divider, one quotient bit a stage ----------------
	function automatic logic [CfgW+QuotW-1:0] div_step(input logic [CfgW-1:0] r,
			input logic [QuotW-1:0] n, input logic [CfgW-1:0] d);
		logic [CfgW:0]   t;
		logic            ge;
		logic [CfgW-1:0] rn;
		t  = {r, n[QuotW-1]};
		ge = t >= {1'b0, d};
		rn = ge ? CfgW'(t - {1'b0, d}) : t[CfgW-1:0];
		return {rn, n[QuotW-2:0], ge};
	endfunction

	logic    dv_v_s [QuotW+1];
	dstage_t dv_s   [QuotW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (div_en) begin
			dv_v_s[0] <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_en) begin
			dv_s[0].func <= in_ch.func;
			dv_s[0].px   <= in_ch.pos_x;
			dv_s[0].py   <= in_ch.pos_y;
			dv_s[0].pix  <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
			dv_s[0].rx   <= '0;
			dv_s[0].ry   <= '0;
			dv_s[0].qx   <= {17'(in_ch.pos_x) * 17'(sw), 8'h00};
			dv_s[0].qy   <= {17'(in_ch.pos_y) * 17'(sh), 8'h00};
		end
	end

	for (genvar k = 0; k < QuotW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (div_en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (div_en) begin
				dv_s[k+1].func <= dv_s[k].func;
				dv_s[k+1].px   <= dv_s[k].px;
				dv_s[k+1].py   <= dv_s[k].py;
				dv_s[k+1].pix  <= dv_s[k].pix;
				{dv_s[k+1].rx, dv_s[k+1].qx} <= div_step(dv_s[k].rx, dv_s[k].qx, bw);
				{dv_s[k+1].ry, dv_s[k+1].qy} <= div_step(dv_s[k].ry, dv_s[k].qy, bh);
			end
		end
	end

	// ---------------- coordinate clamp and neighbor addresses ----------------
	dstage_t         dq;
	logic [CfgW-1:0] ix, iy, ix1, iy1;
	logic [7:0]      fx, fy;
	logic            load_ok;
	logic [AddrW-1:0] ld_addr;

	assign dq = dv_s[QuotW];

	always_comb begin
		if (dq.qx[QuotW-1:8] > 17'(sw_m1)) begin
			ix = sw_m1;
			fx = 8'd0;
		end else begin
			ix = dq.qx[16:8];
			fx = dq.qx[7:0];
		end
		if (dq.qy[QuotW-1:8] > 17'(sh_m1)) begin
			iy = sh_m1;
			fy = 8'd0;
		end else begin
			iy = dq.qy[16:8];
			fy = dq.qy[7:0];
		end
		ix1 = (ix == sw_m1) ? ix : ix + 9'd1;
		iy1 = (iy == sh_m1) ? iy : iy + 9'd1;
	end

	assign load_ok = (32'(dq.px) < MAX_WIDTH) && (32'(dq.py) < MAX_HEIGHT);
	assign ld_addr = AddrW'(AddrW'(dq.py) * AddrW'(MAX_WIDTH)) + AddrW'(dq.px);

	function automatic logic [AddrW-1:0] pix_addr(input logic [CfgW-1:0] x,
			input logic [CfgW-1:0] y);
		return AddrW'(AddrW'(y) * AddrW'(MAX_WIDTH)) + AddrW'(x);
	endfunction

	// ---------------- memory access stage ----------------
	logic [AddrW-1:0] a_addr_s1 [4];
	logic [7:0]       a_fx_s1, a_fy_s1;
	logic [23:0]      a_pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_s1 <= 1'b0;
		end else if (a_take) begin
			a_v_s1 <= dv_v_s[QuotW];
		end
	end

	always_ff @(posedge clk) begin
		if (a_take) begin
			a_func_s1 <= dq.func;
			a_wen_s1  <= load_ok;
			a_fx_s1   <= fx;
			a_fy_s1   <= fy;
			a_pix_s1  <= dq.pix;
			// load address rides in the first slot
			a_addr_s1[0] <= (dq.func == FuncLoad) ? ld_addr : pix_addr(ix, iy);
			a_addr_s1[1] <= pix_addr(ix1, iy);
			a_addr_s1[2] <= pix_addr(ix, iy1);
			a_addr_s1[3] <= pix_addr(ix1, iy1);
		end
	end

	// read sequence counter: c00, c10, c01, c11
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv && a_v_s1 && a_func_s1 == FuncBlend) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	logic        ram_we, ram_re;
	logic [23:0] ram_rdata;

	assign ram_we = adv && a_v_s1 && a_func_s1 == FuncLoad && a_wen_s1;
	assign ram_re = adv && a_v_s1 && a_func_s1 == FuncBlend;

	bsab_ram #(
		.WIDTH(24),
		.DEPTH(Depth)
	) u_img (
		.clk  (clk),
		.we   (ram_we),
		.waddr(a_addr_s1[0]),
		.wdata(a_pix_s1),
		.re   (ram_re),
		.raddr(a_addr_s1[cnt_q]),
		.rdata(ram_rdata)
	);

	// ---------------- read return ----------------
	logic        rp_v_s2;
	logic [1:0]  rp_idx_s2;
	logic [7:0]  rp_fx_s2, rp_fy_s2;
	logic [23:0] rp_pix_s2;
	logic [23:0] c_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_v_s2 <= 1'b0;
		end else if (adv) begin
			rp_v_s2 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rp_idx_s2 <= cnt_q;
			if (ram_re && cnt_q == 2'd3) begin
				rp_fx_s2  <= a_fx_s1;
				rp_fy_s2  <= a_fy_s1;
				rp_pix_s2 <= a_pix_s1;
			end
			if (rp_v_s2 && rp_idx_s2 != 2'd3) begin
				c_q[rp_idx_s2] <= ram_rdata;
			end
		end
	end

	// ---------------- interpolation and blend ----------------
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] w);
		logic [16:0] acc;
		acc = 17'(a) * (17'd256 - 17'(w)) + 17'(b) * 17'(w);
		return acc[15:8];
	endfunction

	logic        b1_v_s3, b2_v_s4;
	logic [7:0]  b1_l_s3 [3];
	logic [7:0]  b1_r_s3 [3];
	logic [7:0]  b1_fx_s3;
	logic [23:0] b1_pix_s3, b2_pix_s4;
	logic [7:0]  b2_s_s4 [3];
	logic [7:0]  out_c_q [3];
	logic [16:0] mix [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_s3 <= 1'b0;
			b2_v_s4 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			b1_v_s3 <= rp_v_s2 && rp_idx_s2 == 2'd3;
			b2_v_s4 <= b1_v_s3;
			out_v_q <= b2_v_s4;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		assign mix[c] = 17'(b2_pix_s4[8*c +: 8]) * 17'(ratio)
			+ 17'(b2_s_s4[c]) * (17'd256 - 17'(ratio));

		always_ff @(posedge clk) begin
			if (adv) begin
				// vertical pass on both columns
				b1_l_s3[c] <= lerp8(c_q[0][8*c +: 8], c_q[2][8*c +: 8], rp_fy_s2);
				b1_r_s3[c] <= lerp8(c_q[1][8*c +: 8], ram_rdata[8*c +: 8], rp_fy_s2);
				// horizontal pass
				b2_s_s4[c] <= lerp8(b1_l_s3[c], b1_r_s3[c], b1_fx_s3);
				// mix with the big pixel
				out_c_q[c] <= mix[c][15:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b1_fx_s3  <= rp_fx_s2;
			b1_pix_s3 <= rp_pix_s2;
			b2_pix_s4 <= b1_pix_s3;
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.out_blue  = out_c_q[0];
	assign out_ch.out_green = out_c_q[1];
	assign out_ch.out_red   = out_c_q[2];

endmodule
`default_nettype wire

>>> dv/tb_bilinear_scale_alpha_blend.sv
// Testbench for bilinear_scale_alpha_blend: directed, random and back-pressure tests.
`default_nettype none
module tb_bilinear_scale_alpha_blend;
	import bsab_pkg::*;

	typedef struct packed {
		logic  func;
		chan_t x;
		chan_t y;
		chan_t b;
		chan_t g;
		chan_t r;
	} beat_t;

	typedef struct packed {
		chan_t b;
		chan_t g;
		chan_t r;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PaddrW-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bsab_in_if  in_ch ();
	bsab_out_if out_ch ();

	bilinear_scale_alpha_blend dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch.sink),
		.out_ch  (out_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the small image and the register file
	logic [23:0] small_img [65536];
	bit          written   [65536];
	logic [CfgW-1:0] ratio_reg, big_w_reg, big_h_reg, small_w_reg, small_h_reg;

	pixel_t expected_pixels[$];
	int     fail_count;
	int     burst_left;
	bit     hold_req;
	int     hold_count;
	int     stall_mode;
	int     mode_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("tb_bilinear_scale_alpha_blend NOT OK");
		$finish;
	end

	// size handling of the block: zero reads as one, small sizes cap at the store
	function automatic int eff_big(input logic [CfgW-1:0] v);
		return (v == 0) ? 1 : int'(v);
	endfunction

	function automatic int eff_small(input logic [CfgW-1:0] v);
		if (v == 0)
			return 1;
		return (v > 256) ? 256 : int'(v);
	endfunction

	// map a big-image coordinate to integer part, clamped next, and Q8 fraction
	function automatic void locate(input int pos, input int sz, input int bg,
		output int i, output int i1, output int f);
		int q;
		q = pos * sz * 256 / bg;
		i = q >> 8;
		f = q & 255;
		if (i > sz - 1) begin
			i = sz - 1;
			f = 0;
		end
		i1 = (i + 1 > sz - 1) ? sz - 1 : i + 1;
	endfunction

	function automatic void neighbors(input chan_t x, input chan_t y,
		output int addr [4], output int fx, output int fy);
		int ix, ix1, iy, iy1;
		locate(x, eff_small(small_w_reg), eff_big(big_w_reg), ix, ix1, fx);
		locate(y, eff_small(small_h_reg), eff_big(big_h_reg), iy, iy1, fy);
		addr[0] = iy * 256 + ix;
		addr[1] = iy * 256 + ix1;
		addr[2] = iy1 * 256 + ix;
		addr[3] = iy1 * 256 + ix1;
	endfunction

	function automatic int mix_lerp(input int a, input int b, input int w);
		return (a * (256 - w) + b * w) >> 8;
	endfunction

	function automatic pixel_t blended_pixel(input beat_t bt);
		int addr [4];
		int fx, fy, ratio, k, left, right, s, big;
		logic [7:0] res [3];
		ratio = (ratio_reg > 256) ? 256 : int'(ratio_reg);
		neighbors(bt.x, bt.y, addr, fx, fy);
		for (k = 0; k < 3; k++) begin
			left  = mix_lerp(small_img[addr[0]][8*k +: 8], small_img[addr[2]][8*k +: 8], fy);
			right = mix_lerp(small_img[addr[1]][8*k +: 8], small_img[addr[3]][8*k +: 8], fy);
			s = mix_lerp(left, right, fx);
			big = (k == 0) ? bt.b : (k == 1) ? bt.g : bt.r;
			res[k] = 8'((big * ratio + s * (256 - ratio)) >> 8);
		end
		return '{b: res[0], g: res[1], r: res[2]};
	endfunction

	// send one beat with bursty pacing, update the shadow once accepted
	task automatic send_beat(input beat_t bt);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_ch.valid    <= 1'b1;
		in_ch.func     <= bt.func;
		in_ch.pos_x    <= bt.x;
		in_ch.pos_y    <= bt.y;
		in_ch.in_blue  <= bt.b;
		in_ch.in_green <= bt.g;
		in_ch.in_red   <= bt.r;
		do @(posedge clk); while (!in_ch.ready);
		if (bt.func == FuncLoad) begin
			small_img[{bt.y, bt.x}] = {bt.r, bt.g, bt.b};
			written[{bt.y, bt.x}] = 1'b1;
		end else begin
			expected_pixels.push_back(blended_pixel(bt));
		end
	endtask

	task automatic load_pixel(input chan_t x, input chan_t y);
		send_beat('{func: FuncLoad, x: x, y: y, b: chan_t'($urandom),
			g: chan_t'($urandom), r: chan_t'($urandom)});
	endtask

	// blend one big pixel, first loading any neighbor not yet in the store
	task automatic blend_at(input chan_t x, input chan_t y, input pixel_t p);
		int addr [4];
		int fx, fy, k;
		neighbors(x, y, addr, fx, fy);
		for (k = 0; k < 4; k++)
			if (!written[addr[k]] || $urandom_range(0, 15) == 0)
				load_pixel(chan_t'(addr[k] % 256), chan_t'(addr[k] / 256));
		if ($urandom_range(0, 7) == 0)
			load_pixel(chan_t'($urandom), chan_t'($urandom));
		send_beat('{func: FuncBlend, x: x, y: y, b: p.b, g: p.g, r: p.r});
	endtask

	task automatic blend_random();
		blend_at(chan_t'($urandom), chan_t'($urandom), pixel_t'(24'($urandom)));
	endtask

	// wait for all results, then for the pipeline to settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CfgW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PaddrW'(idx) << 2;
		pwdata  <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			RegBlendRatio:  ratio_reg   = val;
			RegBigWidth:    big_w_reg   = val;
			RegBigHeight:   big_h_reg   = val;
			RegSmallWidth:  small_w_reg = val;
			RegSmallHeight: small_h_reg = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input int ratio, input int bw, input int bh,
		input int sw, input int sh);
		write_reg(RegBlendRatio, CfgW'(ratio));
		write_reg(RegBigWidth, CfgW'(bw));
		write_reg(RegBigHeight, CfgW'(bh));
		write_reg(RegSmallWidth, CfgW'(sw));
		write_reg(RegSmallHeight, CfgW'(sh));
	endtask

	// reset settings, corner positions and extreme pixel values
	task automatic test_reset_defaults();
		blend_at(8'd0, 8'd0, '{b: 8'd0, g: 8'd0, r: 8'd0});
		blend_at(8'd255, 8'd255, '{b: 8'hff, g: 8'hff, r: 8'hff});
		blend_at(8'd0, 8'd255, '{b: 8'hff, g: 8'd0, r: 8'hff});
		drain();
	endtask

	// zero sizes, oversize small image, ratio 0 / one / above one, positions past the image
	task automatic test_register_extremes();
		int cfgs [5][5] = '{
			'{0, 0, 0, 0, 0},
			'{256, 1, 1, 1, 1},
			'{511, 4, 4, 300, 511},
			'{255, 256, 256, 2, 2},
			'{1, 10, 7, 256, 256}
		};
		int n;
		for (n = 0; n < 5; n++) begin
			set_config(cfgs[n][0], cfgs[n][1], cfgs[n][2], cfgs[n][3], cfgs[n][4]);
			blend_at(8'd0, 8'd0, '{b: 8'hff, g: 8'h00, r: 8'h80});
			blend_at(8'd255, 8'd255, '{b: 8'h00, g: 8'hff, r: 8'h7f});
			blend_random();
			drain();
		end
	endtask

	function automatic int pick_small();
		case ($urandom_range(0, 9))
			0:       return 256;
			1:       return 0;
			2:       return $urandom_range(257, 511);
			default: return $urandom_range(1, 24);
		endcase
	endfunction

	function automatic int pick_big();
		case ($urandom_range(0, 5))
			0:       return 256;
			1:       return $urandom_range(0, 511);
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	function automatic int pick_ratio();
		case ($urandom_range(0, 4))
			0:       return 0;
			1:       return 256;
			default: return $urandom_range(0, 511);
		endcase
	endfunction

	task automatic test_random_configs();
		int n, k;
		for (n = 0; n < 12; n++) begin
			set_config(pick_ratio(), pick_big(), pick_big(), pick_small(), pick_small());
			for (k = 0; k < 35; k++)
				blend_random();
			drain();
		end
	endtask

	// receiver holds off for a long stretch while blends keep coming
	task automatic test_backpressure();
		int k;
		set_config(pick_ratio(), 64, 64, 16, 16);
		for (k = 0; k < 20; k++)
			blend_random();
		hold_req = 1'b1;
		for (k = 0; k < 80; k++)
			blend_random();
		drain();
	endtask

	// result receiver: long hold-off on request, else a changing stall pattern
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_count = 400;
		end
		if (mode_count == 0) begin
			stall_mode = $urandom_range(0, 2);
			mode_count = $urandom_range(16, 128);
		end
		mode_count--;
		if (hold_count > 0) begin
			hold_count--;
			out_ch.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0:       out_ch.ready <= 1'b1;
				1:       out_ch.ready <= $urandom_range(0, 1);
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("result beat with no blend pending");
				fail_count++;
			end else begin
				want = expected_pixels.pop_front();
				if (out_ch.out_blue !== want.b) begin
					$error("out_blue expected %0d got %0d", want.b, out_ch.out_blue);
					fail_count++;
				end
				if (out_ch.out_green !== want.g) begin
					$error("out_green expected %0d got %0d", want.g, out_ch.out_green);
					fail_count++;
				end
				if (out_ch.out_red !== want.r) begin
					$error("out_red expected %0d got %0d", want.r, out_ch.out_red);
					fail_count++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.func = FuncLoad;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.in_blue = '0;
		in_ch.in_green = '0;
		in_ch.in_red = '0;
		out_ch.ready = 1'b0;
		fail_count = 0;
		burst_left = 0;
		hold_req = 1'b0;
		hold_count = 0;
		stall_mode = 0;
		mode_count = 0;
		ratio_reg = RatioReset;
		big_w_reg = SizeReset;
		big_h_reg = SizeReset;
		small_w_reg = SizeReset;
		small_h_reg = SizeReset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_configs();
		test_backpressure();

		if (fail_count == 0)
			$display("tb_bilinear_scale_alpha_blend OK");
		else
			$display("tb_bilinear_scale_alpha_blend NOT OK");
		$finish;
	end

	// a blend left without its result shows up in the timeout
endmodule
`default_nettype wire
